// ----- src/tkf_pkg.sv -----
// Package for the top-k fitness keeper: shared types, field widths, register
// indexes and the score comparison.
// No dependencies; used by every module of the block.
package tkf_pkg;

  // Field widths fixed by the stream formats.
  localparam int unsigned ScoreW = 32;
  localparam int unsigned IdentW = 16;
  localparam int unsigned GenW   = 16;
  localparam int unsigned RankW  = 4;
  localparam int unsigned LcntW  = 5;
  localparam int unsigned CapW   = 5;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InW  = 64;
  localparam int unsigned OutW = 112;

  // Output tdata bit positions, lowest bit of each field.
  localparam int unsigned OutRankLo  = 0;
  localparam int unsigned OutScoreLo = 4;
  localparam int unsigned OutIdentLo = 36;
  localparam int unsigned OutCountLo = 52;
  localparam int unsigned OutBestLo  = 57;
  localparam int unsigned OutBgenLo  = 89;
  localparam int unsigned OutBvalid  = 105;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgKeepHighest = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgCapacity    = 8'd1;

  // Starting record for each mode.
  localparam logic [ScoreW-1:0] WorstHigh = 32'h8000_0000;
  localparam logic [ScoreW-1:0] WorstLow  = 32'h7FFF_FFFF;

  // One list entry as held by a cell.
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [IdentW-1:0] ident;
  } cell_data_t;

  // Control shared by all cells of the chain.
  typedef struct packed {
    logic       insert;
    logic       rotate;
    logic       keep_highest;
    cell_data_t item;
  } cell_ctrl_t;

  // True when score a ranks strictly ahead of score b in the given mode.
  function automatic logic beats(input logic highest, input logic [ScoreW-1:0] a,
                                 input logic [ScoreW-1:0] b);
    logic gt;
    logic lt;
    gt = $signed(a) > $signed(b);
    lt = $signed(a) < $signed(b);
    return highest ? gt : lt;
  endfunction

  function automatic logic [ScoreW-1:0] worst_for(input logic highest);
    return highest ? WorstHigh : WorstLow;
  endfunction

endpackage

// ----- src/tkf_cell.sv -----
// One slot of the sorted list: compares the incoming candidate with its own
// entry and takes the new item, its left neighbor's entry, its right one, or the first cell's entry.
// Depends on tkf_pkg.
module tkf_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                clk_i,
  input  tkf_pkg::cell_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]    used_i,   // entries in use before this request
  input  logic                found_i,  // a cell to the left took the item
  output logic                found_o,
  input  tkf_pkg::cell_data_t prev_i,   // left neighbor's entry
  input  tkf_pkg::cell_data_t next_i,   // right neighbor's entry
  input  tkf_pkg::cell_data_t head_i,   // entry of the first cell
  output tkf_pkg::cell_data_t data_o
);

  localparam logic [CNT_W-1:0] Pos = CNT_W'(INDEX);

  tkf_pkg::cell_data_t data_q, data_d;
  logic in_use;
  logic at_end;
  logic is_tail;
  logic hit;

  assign in_use  = Pos < used_i;
  assign at_end  = Pos == used_i;
  assign is_tail = (Pos + CNT_W'(1)) == used_i;

  // The item goes before the first entry it strictly beats, else at the end if the list has room.
  assign hit     = in_use ? tkf_pkg::beats(ctrl_i.keep_highest, ctrl_i.item.score,
                                           data_q.score)
                          : at_end;
  assign found_o = found_i | hit;

  // Insert shifts toward the tail; rotate moves each entry one place to the head.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.insert) begin
      if (found_i) begin
        data_d = prev_i;
      end else if (hit) begin
        data_d = ctrl_i.item;
      end
    end else if (ctrl_i.rotate) begin
      data_d = is_tail ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- src/top_k_fitness_keeper.sv -----
// Top-k fitness keeper: a chain of DEPTH compare cells holds the sorted list.
// An ordinary request is inserted when taken; one is taken per cycle while idle.
// A request with tlast is inserted, the best record is then updated, and n results
// follow at one per cycle, unless the output stalls, as the chain rotates past its
// first cell; input is held until the final result is loaded into the output register.
// Reset clears the fill count, the best record and output valid; slots are not cleared.
module top_k_fitness_keeper #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tkf_pkg::InW-1:0]       s_axis_tdata,   // score, entry_id, generation
  input  logic                          s_axis_tlast,   // end_of_generation
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // rank, entry_score, entry_ident, list_count, best_score, best_generation,
  // best_valid, zero padding
  output logic [tkf_pkg::OutW-1:0]      m_axis_tdata,
  output logic                          m_axis_tlast,   // last
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tkf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tkf_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration and record registers.
  logic                         keep_q;
  logic [tkf_pkg::CapW-1:0]     cap_q;
  logic [tkf_pkg::ScoreW-1:0]   rec_score_q;
  logic [tkf_pkg::GenW-1:0]     rec_gen_q;
  logic                         rec_valid_q;
  logic [tkf_pkg::GenW-1:0]     gen_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] emit_idx_q, emit_idx_d;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] used;
  logic [CNT_W:0]   grown;

  // Output register.
  logic                         out_valid_q;
  logic [tkf_pkg::RankW-1:0]    out_rank_q;
  tkf_pkg::cell_data_t          out_entry_q;
  logic [tkf_pkg::LcntW-1:0]    out_count_q;
  logic [tkf_pkg::ScoreW-1:0]   out_best_q;
  logic [tkf_pkg::GenW-1:0]     out_bgen_q;
  logic                         out_bvalid_q;
  logic                         out_last_q;

  logic in_req;
  logic load;
  logic emit_last;
  logic cfg_req;
  logic rec_better;

  tkf_pkg::cell_ctrl_t ctrl;
  tkf_pkg::cell_data_t cell_data [DEPTH];
  logic [DEPTH:0]      found;

  assign s_axis_tready = state_q == StIdle;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = state_q == StIdle;
  assign cfg_req       = cfg_valid_i && cfg_ready_o;

  // Capacity out of range is clamped to 1..DEPTH.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign used    = (count_q < cap_eff) ? count_q : cap_eff;
  assign grown   = {1'b0, used} + (CNT_W + 1)'(1);
  assign count_d = (grown < {1'b0, cap_eff}) ? grown[CNT_W-1:0] : cap_eff;

  // Chain control.
  assign ctrl.insert       = in_req;
  assign ctrl.rotate       = load;
  assign ctrl.keep_highest = keep_q;
  assign ctrl.item.score   = s_axis_tdata[31:0];
  assign ctrl.item.ident   = s_axis_tdata[47:32];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tkf_cell #(
      .INDEX(i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .used_i (used),
      .found_i(found[i]),
      .found_o(found[i+1]),
      .prev_i ((i == 0) ? ctrl.item : cell_data[(i == 0) ? 0 : i - 1]),
      .next_i (cell_data[(i == DEPTH - 1) ? 0 : i + 1]),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

  // Sequencing: insert, record check, then the list walk.
  assign rec_better = tkf_pkg::beats(keep_q, cell_data[0].score, rec_score_q);
  assign load       = (state_q == StEmit) && (!out_valid_q || m_axis_tready);
  assign emit_last  = emit_idx_q == (used - CNT_W'(1));

  always_comb begin
    state_d    = state_q;
    emit_idx_d = emit_idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_req && s_axis_tlast) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        state_d    = StEmit;
        emit_idx_d = '0;
      end
      StEmit: begin
        if (load) begin
          emit_idx_d = emit_idx_q + CNT_W'(1);
          if (emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      emit_idx_q  <= '0;
      count_q     <= '0;
      keep_q      <= 1'b1;
      cap_q       <= 5'd16;
      rec_score_q <= tkf_pkg::WorstHigh;
      rec_gen_q   <= '0;
      rec_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      emit_idx_q <= emit_idx_d;
      if (in_req) begin
        count_q <= count_d;
      end
      // Register writes are taken only while the block is idle.
      if (cfg_req) begin
        unique case (cfg_index_i)
          tkf_pkg::CfgKeepHighest: begin
            keep_q <= cfg_data_i[0];
            if (!rec_valid_q) begin
              rec_score_q <= tkf_pkg::worst_for(cfg_data_i[0]);
            end
          end
          tkf_pkg::CfgCapacity: begin
            cap_q <= cfg_data_i[tkf_pkg::CapW-1:0];
          end
          default: ;
        endcase
      end
      if ((state_q == StCheck) && rec_better) begin
        rec_score_q <= cell_data[0].score;
        rec_gen_q   <= gen_q;
        rec_valid_q <= 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      gen_q <= s_axis_tdata[63:48];
    end
    if (load) begin
      out_rank_q   <= tkf_pkg::RankW'(emit_idx_q);
      out_entry_q  <= cell_data[0];
      out_count_q  <= tkf_pkg::LcntW'(used);
      out_best_q   <= rec_score_q;
      out_bgen_q   <= rec_gen_q;
      out_bvalid_q <= rec_valid_q;
      out_last_q   <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'd0, out_bvalid_q, out_bgen_q, out_best_q, out_count_q,
                          out_entry_q.ident, out_entry_q.score, out_rank_q};

endmodule

// ----- src/tkf_checker.sv -----
// Port-level checks for the top-k fitness keeper, bound to the top level.
// Depends on tkf_pkg and top_k_fitness_keeper.
module tkf_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     s_axis_tlast,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [tkf_pkg::OutW-1:0] m_axis_tdata,
  input logic                     m_axis_tlast
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // While a list walk is under way the input side is closed.
  a_walk_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input request taken in the middle of a list walk");

  // An ordinary request produces no result.
  a_plain_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result produced by a request without tlast");

  // An end-of-generation request closes the input for the record check.
  a_eog_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after an end-of-generation request");

  // Once a best is recorded, it stays recorded.
  a_best_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $past(m_axis_tvalid) && $past(m_axis_tdata[tkf_pkg::OutBvalid])
    |-> m_axis_tdata[tkf_pkg::OutBvalid])
    else $error("best_valid dropped after a record was taken");

endmodule

bind top_k_fitness_keeper tkf_checker u_tkf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
